>>> hw/rtl/epba_pkg.sv
// Shared types, constants and helper functions for the entropy pool accounting block.
`timescale 1ns / 1ps
`default_nettype none
package epba_pkg;

  localparam int TS_W       = 48;
  localparam int CREDIT_W   = 25;
  localparam int REQ_W      = 16;
  localparam int POOL_W     = 22;
  localparam int GRANT_W    = 7;
  localparam int EVT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int DIFF_W     = 53;
  localparam int ABS_W      = 51;
  localparam int MSB_W      = 6;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [POOL_W-1:0]  POOL_BYTES_RST = POOL_W'(4096);
  localparam logic [GRANT_W-1:0] GRANT_MAX_RST  = GRANT_W'(32);
  localparam logic [EVT_W-1:0]   MAX_EVENT_RST  = EVT_W'(11);

  typedef enum logic [1:0] {
    OP_TIMING   = 2'd0,
    OP_CREDIT   = 2'd1,
    OP_WITHDRAW = 2'd2,
    OP_DRAIN    = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BYTES = 2'd0,
    REG_GRANT_MAX  = 2'd1,
    REG_MAX_EVENT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [POOL_W-1:0]  pool_bytes;
    logic [GRANT_W-1:0] grant_bytes_max;
    logic [EVT_W-1:0]   event_credit_max;
  } cfg_t;

  typedef struct packed {
    opcode_t             op;
    logic [CREDIT_W-1:0] amount;
    logic [REQ_W-1:0]    request_bytes;
    logic                prng_allowed;
  } job_t;

  function automatic logic [MSB_W-1:0] msb_index(input logic [ABS_W-1:0] v);
    logic [MSB_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ABS_W; i++) begin
      if (v[i]) begin
        idx = MSB_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [ABS_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] neg;
    neg = -v;
    return (v < 0) ? neg[ABS_W-1:0] : v[ABS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/epba_front.sv
// Front end: accepts items, differences timing events and computes their credit.
`timescale 1ns / 1ps
`default_nettype none
module epba_front #(
  parameter int FRAC_BITS = epba_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [epba_pkg::TS_W-1:0]       timestamp,
  input  logic [epba_pkg::CREDIT_W-1:0]   credit_bits,
  input  logic [epba_pkg::REQ_W-1:0]      request_bytes,
  input  logic                            prng_allowed,
  input  epba_pkg::cfg_t                  cfg,
  output logic                            q_push,
  output epba_pkg::job_t                  q_job,
  input  logic                            q_ready
);
  import epba_pkg::*;

  localparam logic [MSB_W:0] FracW = (MSB_W + 1)'(FRAC_BITS);

  logic [TS_W-1:0]          prev_time;
  logic signed [ABS_W-1:0]  pred2;
  logic signed [ABS_W:0]    pred3;

  logic signed [DIFF_W-1:0] ts_s, pt_s, d1, d2, d3, pred2_sum, pred3_sum;
  logic                     accept;

  logic                     a_valid;
  opcode_t                  a_op;
  logic [CREDIT_W-1:0]      a_credit;
  logic [REQ_W-1:0]         a_req;
  logic                     a_prng;
  logic [ABS_W-1:0]         a_abs1, a_abs2, a_abs3;

  logic [MSB_W-1:0]         m1, m2, m3, m12, mmin;
  logic                     any_zero;
  logic [MSB_W:0]           e_raw;
  logic [EVT_W-1:0]         e_credit;

  assign in_ready = !a_valid || q_ready;
  assign accept   = in_valid && in_ready;

  // History is kept as three predictions so that all differences form in parallel.
  always_comb begin
    ts_s      = DIFF_W'({5'b0, timestamp});
    pt_s      = DIFF_W'({5'b0, prev_time});
    d1        = ts_s - pt_s;
    d2        = ts_s - DIFF_W'(pred2);
    d3        = ts_s - DIFF_W'(pred3);
    pred2_sum = ts_s + ts_s - pt_s;
    pred3_sum = ts_s + ts_s + ts_s - pt_s - DIFF_W'(pred2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      pred2     <= '0;
      pred3     <= '0;
      a_valid   <= 1'b0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
        if (opcode_t'(opcode) == OP_TIMING) begin
          prev_time <= timestamp;
          pred2     <= pred2_sum[ABS_W-1:0];
          pred3     <= pred3_sum[ABS_W:0];
        end
      end else if (q_ready) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op     <= opcode_t'(opcode);
      a_credit <= credit_bits;
      a_req    <= request_bytes;
      a_prng   <= prng_allowed;
      a_abs1   <= abs_diff(d1);
      a_abs2   <= abs_diff(d2);
      a_abs3   <= abs_diff(d3);
    end
  end

  // The leading-one position is monotonic, so the minimum can be taken after encoding.
  always_comb begin
    m1       = msb_index(a_abs1);
    m2       = msb_index(a_abs2);
    m3       = msb_index(a_abs3);
    m12      = (m1 < m2) ? m1 : m2;
    mmin     = (m12 < m3) ? m12 : m3;
    any_zero = (a_abs1 == '0) || (a_abs2 == '0) || (a_abs3 == '0);
    if (any_zero || ({1'b0, mmin} < FracW)) begin
      e_raw = '0;
    end else begin
      e_raw = {1'b0, mmin} - FracW;
    end
    if (e_raw > (MSB_W + 1)'(cfg.event_credit_max)) begin
      e_credit = cfg.event_credit_max;
    end else begin
      e_credit = e_raw[EVT_W-1:0];
    end
  end

  always_comb begin
    q_push              = a_valid;
    q_job.op            = a_op;
    q_job.amount        = (a_op == OP_TIMING) ? CREDIT_W'(e_credit) : a_credit;
    q_job.request_bytes = a_req;
    q_job.prng_allowed  = a_prng;
  end

endmodule
`default_nettype wire

>>> hw/rtl/epba_queue.sv
// Short first-in first-out queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none
module epba_queue #(
  parameter int DEPTH = epba_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  epba_pkg::job_t push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output epba_pkg::job_t pop_job,
  input  logic           pop
);
  import epba_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/epba_back.sv
// Back end: applies items to the bit count and registers the results.
`timescale 1ns / 1ps
`default_nettype none
module epba_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  epba_pkg::job_t                q_job,
  output logic                          q_pop,
  input  epba_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [epba_pkg::CREDIT_W-1:0] amount,
  output logic [epba_pkg::CREDIT_W-1:0] pool_bits,
  output logic                          pool_full,
  output logic                          almost_full
);
  import epba_pkg::*;

  logic [CREDIT_W-1:0] bit_count, bit_count_next, amount_next;
  logic                r1_valid;
  logic [CREDIT_W-1:0] r1_amount, r1_bits;
  logic                out_load, r1_free;

  logic [CREDIT_W-1:0] cap;
  logic [CREDIT_W:0]   sum, dif, room;
  logic [POOL_W-1:0]   limit, n1;
  logic [GRANT_W-1:0]  n2;

  assign out_load = r1_valid && (!out_valid || out_ready);
  assign r1_free  = !r1_valid || out_load;
  assign q_pop    = q_valid && r1_free;
  assign cap      = {cfg.pool_bytes, 3'b000};

  always_comb begin
    sum   = {1'b0, bit_count} + {1'b0, q_job.amount};
    limit = bit_count[CREDIT_W-1:3];
    if (!q_job.prng_allowed && (POOL_W'(q_job.request_bytes) > limit)) begin
      n1 = limit;
    end else begin
      n1 = POOL_W'(q_job.request_bytes);
    end
    if (n1 > POOL_W'(cfg.grant_bytes_max)) begin
      n2 = cfg.grant_bytes_max;
    end else begin
      n2 = n1[GRANT_W-1:0];
    end
    dif = {1'b0, bit_count} - {16'b0, n2, 3'b000};
    case (q_job.op)
      OP_TIMING, OP_CREDIT: begin
        amount_next    = q_job.amount;
        bit_count_next = (sum > {1'b0, cap}) ? cap : sum[CREDIT_W-1:0];
      end
      OP_WITHDRAW: begin
        amount_next    = CREDIT_W'(n2);
        bit_count_next = dif[CREDIT_W] ? '0 : dif[CREDIT_W-1:0];
      end
      OP_DRAIN: begin
        amount_next    = '0;
        bit_count_next = '0;
      end
      default: begin
        amount_next    = '0;
        bit_count_next = bit_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
      r1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        bit_count <= bit_count_next;
        r1_valid  <= 1'b1;
      end else if (out_load) begin
        r1_valid  <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign room = {1'b0, cap} - {1'b0, r1_bits};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      r1_amount <= amount_next;
      r1_bits   <= bit_count_next;
    end
    if (out_load) begin
      amount      <= r1_amount;
      pool_bits   <= r1_bits;
      pool_full   <= (r1_bits == cap);
      almost_full <= $signed(room) < $signed({16'b0, cfg.grant_bytes_max, 3'b000});
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/entropy_pool_bit_accounting.sv
// Top level of the entropy pool bit accounting block.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one item per clock cycle unless out_ready stalls it, and returns one
// result per item, in order. An item passes the front stages (differencing, then credit
// encoding) into a queue, and two back stages (bit count update, then flag evaluation)
// to the output register, held in turn in the front register, a queue entry and the
// bit count register. The bit count update sets the unstalled rate of one item per cycle.
// Configuration writes are taken in every cycle and must be made while the block is idle.
module entropy_pool_bit_accounting #(
  parameter int FRAC_BITS   = epba_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = epba_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [epba_pkg::TS_W-1:0]       timestamp,
  input  logic [epba_pkg::CREDIT_W-1:0]   credit_bits,
  input  logic [epba_pkg::REQ_W-1:0]      request_bytes,
  input  logic                            prng_allowed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [epba_pkg::CREDIT_W-1:0]   amount,
  output logic [epba_pkg::CREDIT_W-1:0]   pool_bits,
  output logic                            pool_full,
  output logic                            almost_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [epba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [epba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import epba_pkg::*;

  cfg_t cfg;
  logic q_push, q_ready, q_valid, q_pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_bytes       <= POOL_BYTES_RST;
      cfg.grant_bytes_max  <= GRANT_MAX_RST;
      cfg.event_credit_max <= MAX_EVENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_POOL_BYTES: cfg.pool_bytes       <= cfg_data[POOL_W-1:0];
        REG_GRANT_MAX:  cfg.grant_bytes_max  <= cfg_data[GRANT_W-1:0];
        REG_MAX_EVENT:  cfg.event_credit_max <= cfg_data[EVT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  epba_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .timestamp    (timestamp),
    .credit_bits  (credit_bits),
    .request_bytes(request_bytes),
    .prng_allowed (prng_allowed),
    .cfg          (cfg),
    .q_push       (q_push),
    .q_job        (push_job),
    .q_ready      (q_ready)
  );

  epba_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .push_ready(q_ready),
    .pop_valid (q_valid),
    .pop_job   (pop_job),
    .pop       (q_pop)
  );

  epba_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .amount     (amount),
    .pool_bits  (pool_bits),
    .pool_full  (pool_full),
    .almost_full(almost_full)
  );

endmodule
`default_nettype wire
